### hw/rtl/mlct_pkg.sv
// Shared codes, FSM type and control structs for the MSI/LRU tag store.
`default_nettype none
package mlct_pkg;
  localparam int NUM_CPUS_DEF  = 4;
  localparam int NUM_SETS_DEF  = 64;
  localparam int NUM_WAYS_DEF  = 8;
  localparam int ADDR_BITS_DEF = 48;

  localparam int ADDR_W = 48;   // width of the address field
  localparam int VTAG_W = 48;   // width of the victim tag field
  localparam int IDX_W  = 3;    // index_bits register
  localparam int OFF_W  = 4;    // offset_bits register
  localparam int IDXF_W = 7;    // widest set-index field (2**IDX_W - 1 bits)

  localparam logic [2:0] REQ_PRD   = 3'd0;
  localparam logic [2:0] REQ_PWR   = 3'd1;
  localparam logic [2:0] REQ_SRD   = 3'd2;
  localparam logic [2:0] REQ_SRDX  = 3'd3;
  localparam logic [2:0] REQ_SUPGR = 3'd4;

  localparam logic [1:0] MSI_I = 2'd0;
  localparam logic [1:0] MSI_S = 2'd1;
  localparam logic [1:0] MSI_M = 2'd2;

  localparam logic [2:0] BUS_NONE  = 3'd0;
  localparam logic [2:0] BUS_RD    = 3'd1;
  localparam logic [2:0] BUS_RDX   = 3'd2;
  localparam logic [2:0] BUS_UPGR  = 3'd3;
  localparam logic [2:0] BUS_FLUSH = 3'd4;

  localparam logic [3:0] CFG_INDEX_BITS  = 4'd0;
  localparam logic [3:0] CFG_OFFSET_BITS = 4'd1;

  typedef enum logic [1:0] {FSM_CLEAR, FSM_IDLE, FSM_LOOK} fsm_t;

  typedef struct packed {
    logic clear_we;   // write reset metadata at the sweep row
    logic capture;    // take the input transfer, start the row read
    logic update;     // write back the row and load the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last; // sweep is at the final row
    logic out_free;   // result register can take a new result
  } dp_stat_t;
endpackage
`default_nettype wire

### hw/rtl/mlct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                         clk,
  input  wire                                         we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                            wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/mlct_ctrl.sv
// Controller FSM: reset sweep, capture, lookup and write-back sequencing.
`default_nettype none
module mlct_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  mlct_pkg::dp_stat_t   stat,
  output mlct_pkg::ctrl_cmd_t  cmd
);
  import mlct_pkg::*;

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      FSM_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (stat.clear_last) state_next = FSM_IDLE;
      end
      FSM_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = FSM_LOOK;
      end
      FSM_LOOK: begin
        // hold the row until the result register frees up
        cmd.update = stat.out_free;
        if (stat.out_free) state_next = FSM_IDLE;
      end
      default: state_next = FSM_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/mlct_dp.sv
// Datapath: config, address split, tag/metadata RAMs, MSI and LRU update, result register.
`default_nettype none
module mlct_dp #(
  parameter int NUM_CPUS  = mlct_pkg::NUM_CPUS_DEF,
  parameter int NUM_SETS  = mlct_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS  = mlct_pkg::NUM_WAYS_DEF,
  parameter int ADDR_BITS = mlct_pkg::ADDR_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_valid,
  input  wire  [3:0]           cfg_index,
  input  wire  [3:0]           cfg_data,
  input  wire  [55:0]          s_tdata,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [63:0]          m_tdata,
  input  mlct_pkg::ctrl_cmd_t  cmd,
  output mlct_pkg::dp_stat_t   stat
);
  import mlct_pkg::*;

  localparam int AW   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int ROWS = NUM_CPUS * NUM_SETS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RB   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int MW   = NUM_WAYS * (2 + RB);
  localparam int TW   = NUM_WAYS * AW;
  localparam int NIDX = 1 << IDXF_W;

  logic [IDX_W-1:0] index_bits;
  logic [OFF_W-1:0] offset_bits;

  // input unpack and address split
  logic [2:0]        in_req;
  logic [1:0]        in_cpu;
  logic [AW-1:0]     in_addr;
  logic [IDXF_W-1:0] in_idx;
  logic [AW-1:0]     in_tag;
  logic [SW-1:0]     set_tab [NIDX];
  logic [RW-1:0]     in_row;
  logic              in_bad;

  logic [2:0]    req_q;
  logic [AW-1:0] tag_q;
  logic [RW-1:0] row_q;
  logic          bad_q;
  logic [RW-1:0] clr_row;

  logic [TW-1:0] tag_rd, tag_wd;
  logic [MW-1:0] meta_rd, meta_wd, meta_clr;
  logic [RW-1:0] raddr, waddr;
  logic          tag_we, meta_we;

  // lookup
  logic [1:0]    st     [NUM_WAYS];
  logic [RB-1:0] rk     [NUM_WAYS];
  logic [AW-1:0] tg     [NUM_WAYS];
  logic [1:0]    st_new [NUM_WAYS];
  logic [RB-1:0] rk_new [NUM_WAYS];
  logic          hit;
  logic [RB-1:0] hway, lway, way;
  logic [1:0]    prior, nxt;
  logic [2:0]    bus;
  logic          is_proc, do_meta, newest;
  logic          vvalid, vdirty;
  logic [AW-1:0] vtag;
  logic [RB-1:0] r_sel;

  assign in_req  = s_tdata[2:0];
  assign in_cpu  = s_tdata[4:3];
  assign in_addr = s_tdata[5 +: AW];

  for (genvar i = 0; i < NIDX; i++) begin : g_set
    assign set_tab[i] = SW'(i % NUM_SETS);
  end

  always_comb begin
    in_idx = IDXF_W'(in_addr >> offset_bits) & ~({IDXF_W{1'b1}} << index_bits);
    in_tag = in_addr >> ({1'b0, offset_bits} + 5'(index_bits));
    in_row = RW'(32'(in_cpu) * NUM_SETS + 32'(set_tab[in_idx]));
    in_bad = (in_req > REQ_SUPGR) || (32'(in_cpu) >= NUM_CPUS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits  <= IDX_W'(6);
      offset_bits <= OFF_W'(6);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_INDEX_BITS)  index_bits  <= cfg_data[IDX_W-1:0];
      if (cfg_index == CFG_OFFSET_BITS) offset_bits <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= in_req;
      tag_q <= in_tag;
      row_q <= in_row;
      bad_q <= in_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clear_we) begin
      clr_row <= clr_row + RW'(1);
    end
  end

  assign raddr = cmd.capture ? in_row : row_q;
  assign waddr = cmd.clear_we ? clr_row : row_q;

  mlct_ram #(.WIDTH(TW), .DEPTH(ROWS)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(waddr), .wdata(tag_wd), .raddr(raddr), .rdata(tag_rd)
  );

  mlct_ram #(.WIDTH(MW), .DEPTH(ROWS)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(waddr), .wdata(meta_wd), .raddr(raddr), .rdata(meta_rd)
  );

  always_comb begin
    hit  = 1'b0;
    hway = '0;
    lway = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      st[w] = meta_rd[2*w +: 2];
      rk[w] = meta_rd[2*NUM_WAYS + RB*w +: RB];
      tg[w] = tag_rd[AW*w +: AW];
    end
    // scan downward so the lowest matching way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (st[w] != MSI_I && tg[w] == tag_q) begin
        hit  = 1'b1;
        hway = RB'(w);
      end
      if (rk[w] == '0) lway = RB'(w);
    end

    is_proc = (req_q == REQ_PRD) || (req_q == REQ_PWR);
    prior   = hit ? st[hway] : MSI_I;
    way     = (is_proc && !hit) ? lway : hway;
    nxt     = MSI_I;
    bus     = BUS_NONE;
    if (req_q == REQ_PWR) begin
      nxt = MSI_M;
      bus = (prior == MSI_I) ? BUS_RDX : (prior == MSI_S) ? BUS_UPGR : BUS_NONE;
    end else if (req_q == REQ_PRD) begin
      nxt = (prior == MSI_M) ? MSI_M : MSI_S;
      bus = (prior == MSI_I) ? BUS_RD : BUS_NONE;
    end else if (hit) begin
      nxt = (req_q == REQ_SRD) ? MSI_S : MSI_I;
      bus = (prior == MSI_M) ? BUS_FLUSH : BUS_NONE;
    end

    vvalid = is_proc && !hit && st[lway] != MSI_I;
    vdirty = vvalid && st[lway] == MSI_M;
    vtag   = vvalid ? tg[lway] : '0;

    do_meta = !bad_q && (is_proc || hit);
    newest  = nxt != MSI_I;
    r_sel   = rk[way];
    for (int w = 0; w < NUM_WAYS; w++) begin
      st_new[w] = st[w];
      rk_new[w] = rk[w];
      if (newest && rk[w] > r_sel) rk_new[w] = rk[w] - RB'(1);
      if (!newest && rk[w] < r_sel) rk_new[w] = rk[w] + RB'(1);
      if (RB'(w) == way) begin
        st_new[w] = nxt;
        rk_new[w] = newest ? RB'(NUM_WAYS - 1) : '0;
      end
    end

    tag_wd = tag_rd;
    tag_wd[AW*way +: AW] = tag_q;
    for (int w = 0; w < NUM_WAYS; w++) begin
      meta_wd[2*w +: 2]                  = st_new[w];
      meta_wd[2*NUM_WAYS + RB*w +: RB]   = rk_new[w];
      meta_clr[2*w +: 2]                 = MSI_I;
      meta_clr[2*NUM_WAYS + RB*w +: RB]  = RB'(w);
    end
    if (cmd.clear_we) meta_wd = meta_clr;

    meta_we = cmd.clear_we || (cmd.update && do_meta);
    tag_we  = cmd.update && !bad_q && is_proc && !hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (bad_q) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {6'd0, VTAG_W'(vtag), vdirty, vvalid, bus, nxt, prior, hit};
      end
    end
  end

  assign stat.clear_last = (32'(clr_row) == ROWS - 1);
  assign stat.out_free   = !m_tvalid || m_tready;
endmodule
`default_nettype wire

### hw/rtl/msi_lru_cache_tag_state.sv
// Top level of the MSI coherence tag store with LRU replacement.
// Keeps tag, MSI state and LRU rank for every way of every set of NUM_CPUS caches.
// Each request is first captured while its set's row is read from the tag and metadata
// RAMs (one row holds all ways); it is then looked up, the MSI transition applied and
// the row written back once the result register is free.
// A finished result waits in an output register while the next request is read.
// After reset a clearing pass over all NUM_CPUS*NUM_SETS rows (256 by default) writes
// the reset metadata; s_tready stays low until it ends. Config writes are always taken.
`default_nettype none
module msi_lru_cache_tag_state #(
  parameter int NUM_CPUS  = mlct_pkg::NUM_CPUS_DEF,
  parameter int NUM_SETS  = mlct_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS  = mlct_pkg::NUM_WAYS_DEF,
  parameter int ADDR_BITS = mlct_pkg::ADDR_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [3:0]  cfg_index,
  input  wire  [3:0]  cfg_data,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [55:0] s_tdata,   // req_type[2:0], cpu_id[4:3], address[52:5]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata    // hit[0], prior_state[2:1], next_state[4:3],
                                 // bus_action[7:5], victim_valid[8],
                                 // victim_dirty[9], victim_tag[57:10]
);
  import mlct_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  mlct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  mlct_dp #(
    .NUM_CPUS(NUM_CPUS), .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS), .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cmd(cmd), .stat(stat)
  );
endmodule
`default_nettype wire
